>>> design/gdd_pkg.sv
`default_nettype none

package gdd_pkg;

  // field widths
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned DiffW = 23;

  // day number of any date that fits the fields
  localparam int unsigned NumW = 23;

  // widest legal year
  localparam int unsigned MaxYear = 9999;

  // largest magnitude of the difference
  localparam int unsigned DiffMax = 2 ** (DiffW - 1) - 1;

  // floor(x / 100) as (x * Div100Mul) >> Div100Shift, exact for x below 43690
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned Div100ProdW = YearW + 13;
  localparam int unsigned CentW       = Div100ProdW - Div100Shift;

  localparam int unsigned MonthDaysW = 9;
  localparam int unsigned YearDivW   = YearW - 2;

  // month codes
  localparam logic [MonW-1:0] MonJan = MonW'(1);
  localparam logic [MonW-1:0] MonFeb = MonW'(2);
  localparam logic [MonW-1:0] MonDec = MonW'(12);

  // date after the first pipeline register
  typedef struct packed {
    logic [DayW-1:0]       day;
    logic [MonthDaysW-1:0] mstart;
    logic                  past_feb;
    logic [YearW-1:0]      year;
    logic [YearW-1:0]      prev_year;
    logic [CentW-1:0]      year_cent;
    logic [CentW-1:0]      prev_cent;
  } gdd_s1_t;

  // date after the second pipeline register
  typedef struct packed {
    logic [NumW-1:0]       year_days;
    logic [YearDivW-1:0]   leap_days;
    logic [MonthDaysW-1:0] month_days;
  } gdd_s2_t;

  // days before the first of each month in a common year
  function automatic logic [MonthDaysW-1:0] month_start(input logic [MonW-1:0] mon);
    logic [MonthDaysW-1:0] res;
    unique case (mon)
      4'd1:    res = MonthDaysW'(0);
      4'd2:    res = MonthDaysW'(31);
      4'd3:    res = MonthDaysW'(59);
      4'd4:    res = MonthDaysW'(90);
      4'd5:    res = MonthDaysW'(120);
      4'd6:    res = MonthDaysW'(151);
      4'd7:    res = MonthDaysW'(181);
      4'd8:    res = MonthDaysW'(212);
      4'd9:    res = MonthDaysW'(243);
      4'd10:   res = MonthDaysW'(273);
      4'd11:   res = MonthDaysW'(304);
      4'd12:   res = MonthDaysW'(334);
      default: res = MonthDaysW'(0);
    endcase
    return res;
  endfunction

  // reciprocal multiply in place of a divider
  function automatic logic [CentW-1:0] div100(input logic [YearW-1:0] x);
    logic [Div100ProdW-1:0] prod;
    prod = Div100ProdW'(x) * Div100ProdW'(Div100Mul);
    return prod[Div100ProdW-1:Div100Shift];
  endfunction

endpackage

`default_nettype wire

>>> design/gdd_if.sv
`default_nettype none

interface gdd_in_if import gdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DayW-1:0]  later_day;
  logic [MonW-1:0]  later_month;
  logic [YearW-1:0] later_year;
  logic [DayW-1:0]  earlier_day;
  logic [MonW-1:0]  earlier_month;
  logic [YearW-1:0] earlier_year;

  modport source (
    output valid, later_day, later_month, later_year,
           earlier_day, earlier_month, earlier_year,
    input  ready
  );
  modport sink (
    input  valid, later_day, later_month, later_year,
           earlier_day, earlier_month, earlier_year,
    output ready
  );
endinterface

interface gdd_out_if import gdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DiffW-1:0] day_difference;
  logic                    date_invalid;

  modport source (output valid, day_difference, date_invalid, input ready);
  modport sink (input valid, day_difference, date_invalid, output ready);
endinterface

`default_nettype wire

>>> design/gregorian_date_difference.sv
// gregorian day-number difference
//
// in_i carries one word per pair of dates (later and earlier day, month,
// year); out_o carries one word per pair: later day number minus earlier
// day number, signed, and a flag for a month or year out of range (the
// difference then reads zero). days are taken as given, unchecked.
//
// four register stages: reciprocal divides by 100, the 365-day multiply,
// the day-number sums, then subtract and clamp into the output register.
// out_o.valid rises once the pair has moved through the stage 1, 2 and 3
// registers into the output register; one word is taken every cycle while the
// receiver keeps up.
//
// valid bits travel with the data. when out_o.ready is low only the
// stages behind a full stage hold, so bubbles close up and in_i.ready
// falls only once all four stages are full; nothing is lost or repeated.
//
// reset clears every valid bit; the data registers keep whatever they
// held, and no output word appears until a new pair is accepted.
`default_nettype none

module gregorian_date_difference import gdd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gdd_in_if.sink     in_i,
  gdd_out_if.source  out_o
);

  localparam logic signed [DiffW:0] SatHi = (DiffW + 1)'(DiffMax);
  localparam logic signed [DiffW:0] SatLo = -SatHi;

  // per-stage advance, rippling back from the output register
  logic en1, en2, en3, eno;

  logic v1_q, v2_q, v3_q, vo_q;

  gdd_s1_t s1_l_d, s1_e_d, s1_l_q, s1_e_q;
  logic    inv1_d, inv1_q;
  gdd_s2_t s2_l_d, s2_e_d, s2_l_q, s2_e_q;
  logic    inv2_q;
  logic [NumW-1:0] n_l_d, n_e_d, n_l_q, n_e_q;
  logic    inv3_q;

  logic signed [DiffW:0]   diff_raw;
  logic signed [DiffW-1:0] diff_d, diff_q;
  logic                    inv_o_q;

  assign eno = !vo_q || out_o.ready;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;

  // range check of month and year
  function automatic logic date_ok(input logic [MonW-1:0] mon, input logic [YearW-1:0] yr);
    return (mon >= MonJan) && (mon <= MonDec) && (yr != '0) && (yr <= YearW'(MaxYear));
  endfunction

  // stage 1: lookups and the two divides by 100 per date
  function automatic gdd_s1_t stage1(input logic [DayW-1:0] dy, input logic [MonW-1:0] mon,
                                     input logic [YearW-1:0] yr);
    gdd_s1_t r;
    r.day       = dy;
    r.mstart    = month_start(mon);
    r.past_feb  = (mon > MonFeb);
    r.year      = yr;
    r.prev_year = yr - YearW'(1);
    r.year_cent = div100(yr);
    r.prev_cent = div100(yr - YearW'(1));
    return r;
  endfunction

  // stage 2: leap test, whole-year days and the month part
  function automatic gdd_s2_t stage2(input gdd_s1_t s);
    gdd_s2_t r;
    logic    leap;
    leap = (s.year[1:0] == 2'b00) &&
           ((s.year != YearW'(s.year_cent) * YearW'(100)) || (s.year_cent[1:0] == 2'b00));
    r.year_days  = NumW'(s.prev_year) * NumW'(365);
    // py/4 - py/100 + py/400, never negative
    r.leap_days  = YearDivW'(s.prev_year >> 2) - YearDivW'(s.prev_cent)
                 + YearDivW'(s.prev_cent >> 2);
    r.month_days = MonthDaysW'(s.day) + s.mstart
                 + MonthDaysW'(s.past_feb && leap);
    return r;
  endfunction

  assign s1_l_d = stage1(in_i.later_day, in_i.later_month, in_i.later_year);
  assign s1_e_d = stage1(in_i.earlier_day, in_i.earlier_month, in_i.earlier_year);
  assign inv1_d = !(date_ok(in_i.later_month, in_i.later_year) &&
                    date_ok(in_i.earlier_month, in_i.earlier_year));

  assign s2_l_d = stage2(s1_l_q);
  assign s2_e_d = stage2(s1_e_q);

  // stage 3: day numbers
  assign n_l_d = s2_l_q.year_days + NumW'(s2_l_q.leap_days) + NumW'(s2_l_q.month_days);
  assign n_e_d = s2_e_q.year_days + NumW'(s2_e_q.leap_days) + NumW'(s2_e_q.month_days);

  // stage 4: subtract, clamp, zero on a bad date
  assign diff_raw = $signed({1'b0, n_l_q}) - $signed({1'b0, n_e_q});

  always_comb begin
    if (inv3_q) begin
      diff_d = '0;
    end else if (diff_raw > SatHi) begin
      diff_d = SatHi[DiffW-1:0];
    end else if (diff_raw < SatLo) begin
      diff_d = SatLo[DiffW-1:0];
    end else begin
      diff_d = diff_raw[DiffW-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // data registers, loaded only with a valid word
  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_l_q <= s1_l_d;
      s1_e_q <= s1_e_d;
      inv1_q <= inv1_d;
    end
    if (en2 && v1_q) begin
      s2_l_q <= s2_l_d;
      s2_e_q <= s2_e_d;
      inv2_q <= inv1_q;
    end
    if (en3 && v2_q) begin
      n_l_q  <= n_l_d;
      n_e_q  <= n_e_d;
      inv3_q <= inv2_q;
    end
    if (eno && v3_q) begin
      diff_q  <= diff_d;
      inv_o_q <= inv3_q;
    end
  end

  assign out_o.valid          = vo_q;
  assign out_o.day_difference = diff_q;
  assign out_o.date_invalid   = inv_o_q;

endmodule

`default_nettype wire

>>> design/gdd_checker.sv
`default_nettype none

module gdd_checker import gdd_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic signed [DiffW-1:0] day_difference_i,
  input wire logic                    date_invalid_i
);

  localparam logic signed [DiffW-1:0] DiffMin = -(DiffW'(DiffMax));

  // no word in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output word during reset");

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(day_difference_i)
                                    && $stable(date_invalid_i))
    else $error("stalled output word changed");

  // a bad date reports a zero difference
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && date_invalid_i |-> day_difference_i == '0)
    else $error("invalid date with nonzero difference");

  // clamp never leaves the most negative code
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> day_difference_i >= DiffMin)
    else $error("difference outside clamp range");

  // input is never refused while the pipeline has room at the output
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i || !in_valid_i || in_ready_i)
    else $error("input blocked with an empty output");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .day_difference_i(out_o.day_difference),
  .date_invalid_i  (out_o.date_invalid)
);

`default_nettype wire

>>> tb/gdd_diff_checker.sv
`default_nettype none

module gdd_diff_checker import gdd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gdd_in_if           in_mon,
  gdd_out_if          out_mon,
  output int unsigned mismatches_o,
  output int unsigned waiting_o,
  output int unsigned checked_o,
  output int unsigned flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;
  localparam longint      DiffLimit   = DiffMax;

  typedef struct packed {
    logic signed [DiffW-1:0] diff;
    logic                    invalid;
  } diff_word_t;

  diff_word_t  awaited_diffs[$];
  int unsigned mismatches = 0;
  int unsigned waiting    = 0;
  int unsigned checked    = 0;
  int unsigned flagged    = 0;

  assign mismatches_o = mismatches;
  assign waiting_o    = waiting;
  assign checked_o    = checked;
  assign flagged_o    = flagged;

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // odd months up to july and even ones from august have 31 days
  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    if (m == MonFeb) return 28 + int'(leap_year(y));
    return 30 + ((m + m / 8) % 2);
  endfunction

  // days since 1 january of year 1, that day being 1
  function automatic int unsigned day_number(logic [DayW-1:0] d, logic [MonW-1:0] m,
                                             logic [YearW-1:0] y);
    int unsigned past;
    int unsigned n;
    int unsigned mm;
    past = int'(y) - 1;
    n = int'(d) + past * 365 + past / 4 - past / 100 + past / 400;
    for (mm = MonJan; mm < m; mm++) n += month_length(mm, y);
    return n;
  endfunction

  function automatic bit date_in_range(logic [MonW-1:0] m, logic [YearW-1:0] y);
    return m >= MonJan && m <= MonDec && y >= 1 && y <= MaxYear;
  endfunction

  function automatic diff_word_t date_pair_difference(
    logic [DayW-1:0] ld, logic [MonW-1:0] lm, logic [YearW-1:0] ly,
    logic [DayW-1:0] ed, logic [MonW-1:0] em, logic [YearW-1:0] ey);
    diff_word_t w;
    longint     gap;
    w.diff    = '0;
    w.invalid = 1'b0;
    if (date_in_range(lm, ly) && date_in_range(em, ey)) begin
      gap = longint'(day_number(ld, lm, ly)) - longint'(day_number(ed, em, ey));
      if (gap > DiffLimit) gap = DiffLimit;
      if (gap < -DiffLimit) gap = -DiffLimit;
      w.diff = DiffW'(gap);
    end else begin
      w.invalid = 1'b1;
    end
    return w;
  endfunction

  always @(posedge clk_i) begin : watch
    diff_word_t want;
    if (rst_ni) begin
      // result side first: the block registers its result, so a word leaving
      // now never belongs to the pair taken at this same edge
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_diffs.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%t: unexpected result word, day_difference %0d date_invalid %b",
                     $time, $signed(out_mon.day_difference), out_mon.date_invalid);
        end else begin
          want = awaited_diffs.pop_front();
          checked++;
          if (want.invalid) flagged++;
          if (out_mon.day_difference !== want.diff ||
              out_mon.date_invalid !== want.invalid) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("%t: result %0d: day_difference %0d, wanted %0d; date_invalid %b, wanted %b",
                       $time, checked, $signed(out_mon.day_difference), $signed(want.diff),
                       out_mon.date_invalid, want.invalid);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_diffs.push_back(date_pair_difference(
          in_mon.later_day, in_mon.later_month, in_mon.later_year,
          in_mon.earlier_day, in_mon.earlier_month, in_mon.earlier_year));
      waiting = awaited_diffs.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/gregorian_date_difference_test.sv
`default_nettype none

module gregorian_date_difference_test;
  import gdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned RandomPairs = 1400;
  // far above the worst case for all pairs, so this leaves a wide margin
  localparam int unsigned CycleLimit  = 400_000;
  // pipeline depth plus a little slack for the final drain
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxWait     = 16;
  localparam int unsigned YearTop     = 2 ** YearW - 1;
  localparam int unsigned MonTop      = 2 ** MonW - 1;

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } date_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gdd_in_if  in_if ();
  gdd_out_if out_if ();

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned checked;
  int unsigned flagged;

  int unsigned cycle_count = 0;
  int unsigned sent        = 0;
  int unsigned directed    = 0;
  int unsigned taken       = 0;
  bit          src_steady  = 1'b0;
  bit          snk_steady  = 1'b0;

  gregorian_date_difference dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gdd_diff_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .checked_o    (checked),
    .flagged_o    (flagged)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // watchdog: also the bound on the final drain
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count, waiting);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic date_t on_day(int unsigned d, int unsigned m, int unsigned y);
    date_t t;
    t.day   = DayW'(d);
    t.month = MonW'(m);
    t.year  = YearW'(y);
    return t;
  endfunction

  // years lean towards the edges of the range and towards century years,
  // where the leap rule has its exceptions
  function automatic date_t random_date();
    date_t t;
    t.day   = DayW'($urandom_range(0, 2 ** DayW - 1));
    t.month = MonW'($urandom_range(MonJan, MonDec));
    case ($urandom_range(0, 7))
      0:       t.year = YearW'($urandom_range(1, 12));
      1:       t.year = YearW'(MaxYear - $urandom_range(0, 12));
      2:       t.year = YearW'($urandom_range(1, MaxYear / 100) * 100 + $urandom_range(0, 2) - 1);
      3:       t.year = YearW'($urandom_range(1, MaxYear / 400) * 400);
      default: t.year = YearW'($urandom_range(1, MaxYear));
    endcase
    return t;
  endfunction

  // a date within a year or so of another, for small differences either way
  function automatic date_t date_near(date_t base);
    date_t t;
    int    y;
    t = random_date();
    y = int'(base.year) + $urandom_range(0, 2) - 1;
    if (y < 1) y = 1;
    if (y > int'(MaxYear)) y = MaxYear;
    t.year = YearW'(y);
    return t;
  endfunction

  // push one field of a date out of range
  function automatic date_t spoil(date_t t);
    case ($urandom_range(0, 3))
      0:       t.month = '0;
      1:       t.month = MonW'($urandom_range(MonDec + 1, MonTop));
      2:       t.year  = '0;
      default: t.year  = YearW'($urandom_range(MaxYear + 1, YearTop));
    endcase
    return t;
  endfunction

  // one word on the input channel, after a random gap; called at a falling edge
  // and returns at the falling edge after the word was taken
  task automatic send_pair(input date_t later, input date_t earlier);
    int unsigned gap;
    // every so often switch between idling and a steady stream
    if (sent % 50 == 0) src_steady = ($urandom_range(0, 3) == 0);
    gap = src_steady ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.later_day     = later.day;
    in_if.later_month   = later.month;
    in_if.later_year    = later.year;
    in_if.earlier_day   = earlier.day;
    in_if.earlier_month = earlier.month;
    in_if.earlier_year  = earlier.year;
    in_if.valid         = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    sent++;
  endtask

  // result side: a random stall before each word, with steady stretches
  initial begin : result_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 40 == 0) snk_steady = ($urandom_range(0, 3) == 0);
      stall = snk_steady ? 0 : $urandom_range(0, MaxWait);
      @(negedge clk_i);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
    end
  end

  initial begin : stimulus
    date_t later;
    date_t earlier;
    in_if.valid         = 1'b0;
    in_if.later_day     = '0;
    in_if.later_month   = '0;
    in_if.later_year    = '0;
    in_if.earlier_day   = '0;
    in_if.earlier_month = '0;
    in_if.earlier_year  = '0;

    // reset held low from the start, released at a falling edge, away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: both ends of the calendar and the leap rule around february
    send_pair(on_day(1, MonJan, 1), on_day(1, MonJan, 1));
    send_pair(on_day(31, MonDec, MaxYear), on_day(1, MonJan, 1));
    send_pair(on_day(1, MonJan, 1), on_day(31, MonDec, MaxYear));
    send_pair(on_day(0, MonJan, 1), on_day(31, MonDec, MaxYear));
    // divisible by 400, so a leap year
    send_pair(on_day(1, 3, 2000), on_day(29, MonFeb, 2000));
    // divisible by 100 only, so a common year
    send_pair(on_day(1, 3, 1900), on_day(28, MonFeb, 1900));
    // ordinary leap year
    send_pair(on_day(1, 3, 2004), on_day(28, MonFeb, 2004));
    send_pair(on_day(1, 3, 2400), on_day(1, MonFeb, 2400));
    send_pair(on_day(31, MonDec, 2000), on_day(1, MonJan, 2000));
    send_pair(on_day(1, MonJan, 2001), on_day(31, MonDec, 2000));
    // day field taken as given: 0 and 31 february
    send_pair(on_day(0, MonFeb, 2023), on_day(31, MonJan, 2023));
    send_pair(on_day(31, MonFeb, 2023), on_day(1, 3, 2023));
    // across the top bit of the year field
    send_pair(on_day(31, MonDec, 8191), on_day(0, MonJan, 8192));
    // month out of range in either date
    send_pair(on_day(15, 0, 2000), on_day(1, MonJan, 2000));
    send_pair(on_day(1, MonJan, 2000), on_day(1, MonDec + 1, 2000));
    send_pair(on_day(31, MonTop, 1999), on_day(1, MonJan, 1));
    // year out of range in either date
    send_pair(on_day(1, MonJan, 0), on_day(1, MonJan, 1));
    send_pair(on_day(1, MonJan, 1), on_day(1, MonJan, MaxYear + 1));
    send_pair(on_day(31, MonDec, MaxYear), on_day(31, MonTop, YearTop));
    // every field at all ones in both dates
    send_pair(on_day(31, MonTop, YearTop), on_day(31, MonTop, YearTop));
    directed = sent;

    // random pairs: mostly well-formed dates, some close together, a tenth spoiled
    repeat (RandomPairs) begin
      later   = random_date();
      earlier = ($urandom_range(0, 3) == 0) ? date_near(later) : random_date();
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) later = spoil(later);
        else earlier = spoil(earlier);
      end
      if ($urandom_range(0, 1) == 0) send_pair(later, earlier);
      else send_pair(earlier, later);
    end
    in_if.valid = 1'b0;

    // let every owed result come out, then a few quiet cycles for stray words
    while (waiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d date pairs sent (%0d directed), %0d differences checked, %0d of them invalid",
             sent, directed, checked, flagged);
    $display("%0d cycles with random gaps on both channels, %0d mismatches",
             cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
